// ===== hw/rtl/cdcmp_pkg.sv =====
// Types, codes and date arithmetic for the calendar date comparator.
package cdcmp_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned SodW    = 17;
  localparam int unsigned OrderW  = 2;

  // Multiplicative inverse of 25 modulo 2**14; a year is a multiple of 25
  // exactly when year * Inv25 (mod 2**14) does not exceed Div25Max.
  localparam logic [YearW-1:0] Inv25    = 14'd7209;
  localparam logic [YearW-1:0] Div25Max = 14'(((1 << YearW) - 1) / 25);

  // Order codes
  typedef enum logic [OrderW-1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } order_e;

  // One broken-down timestamp
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } date_t;

  // Derived values of one timestamp
  typedef struct packed {
    logic [DoyW-1:0] doy;
    logic [SodW-1:0] sod;
    logic            ok;
  } date_info_t;

  // Gregorian leap rule without a divider
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [2*YearW-1:0] prod;
    logic               div25;
    begin
      prod  = (2*YearW)'(y) * (2*YearW)'(Inv25);
      div25 = (prod[YearW-1:0] <= Div25Max);
      // century years must also be multiples of 400, i.e. of 16
      is_leap = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    end
  endfunction

  // Days in all months before m in a common year; code 0 counts as month 1, codes 13, 14 and 15 give 365, 364 and 363
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    begin
      unique case (m)
        4'd0, 4'd1: days_before = 9'd0;
        4'd2:       days_before = 9'd31;
        4'd3:       days_before = 9'd59;
        4'd4:       days_before = 9'd90;
        4'd5:       days_before = 9'd120;
        4'd6:       days_before = 9'd151;
        4'd7:       days_before = 9'd181;
        4'd8:       days_before = 9'd212;
        4'd9:       days_before = 9'd243;
        4'd10:      days_before = 9'd273;
        4'd11:      days_before = 9'd304;
        4'd12:      days_before = 9'd334;
        4'd13:      days_before = 9'd365;
        4'd14:      days_before = 9'd364;
        default:    days_before = 9'd363;
      endcase
    end
  endfunction

  // Length of month m; zero for codes that name no month
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
        4'd2:    month_len = leap ? 5'd29 : 5'd28;
        default: month_len = 5'd0;
      endcase
    end
  endfunction

  // Day of year, second of day and range check of one timestamp
  function automatic date_info_t date_eval(input date_t dt);
    date_info_t      r;
    logic            leap;
    logic [DoyW-1:0] day_off;
    logic [DoyW-1:0] leap_adj;
    logic [DayW-1:0] len;
    begin
      leap     = is_leap(dt.year);
      day_off  = (dt.day != '0) ? DoyW'(dt.day - 5'd1) : '0;
      leap_adj = (leap && dt.month >= 4'd3) ? 9'd1 : 9'd0;
      r.doy    = 9'd1 + days_before(dt.month) + leap_adj + day_off;
      r.sod    = SodW'(dt.hour) * 17'd3600 + SodW'(dt.minute) * 17'd60
               + SodW'(dt.second);
      len      = month_len(dt.month, leap);
      // month codes without a length give len zero, failing the day check
      r.ok     = (dt.day != '0) && (dt.day <= len) && (dt.hour < 5'd24)
               && (dt.minute < 6'd60) && (dt.second <= 6'd61);
      date_eval = r;
    end
  endfunction

endpackage

// ===== hw/rtl/calendar_date_compare.sv =====
// Top level of the calendar date comparator: input stage, evaluation, result stage.
//
// Compares two Gregorian timestamps and reports, for each, the 1-based day of
// year, the second of day and a range check, plus the order of the two dates
// (by year, then day of year, then second of day; computed whatever the range
// check says). One word is taken per cycle while the input does not stall;
// an accepted word is held in the input register, and its result is
// registered in the result register after one pass of date arithmetic. While
// a finished result waits, an empty input register still takes one more word,
// and the input stalls after that until the result is taken.
module calendar_date_compare
  import cdcmp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [YearW-1:0]    year_a_i,
  input  logic [MonthW-1:0]   month_a_i,
  input  logic [DayW-1:0]     day_a_i,
  input  logic [HourW-1:0]    hour_a_i,
  input  logic [MinuteW-1:0]  minute_a_i,
  input  logic [SecondW-1:0]  second_a_i,
  input  logic [YearW-1:0]    year_b_i,
  input  logic [MonthW-1:0]   month_b_i,
  input  logic [DayW-1:0]     day_b_i,
  input  logic [HourW-1:0]    hour_b_i,
  input  logic [MinuteW-1:0]  minute_b_i,
  input  logic [SecondW-1:0]  second_b_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OrderW-1:0]   order_o,
  output logic [DoyW-1:0]     day_of_year_a_o,
  output logic [SodW-1:0]     second_of_day_a_o,
  output logic                valid_a_o,
  output logic [DoyW-1:0]     day_of_year_b_o,
  output logic [SodW-1:0]     second_of_day_b_o,
  output logic                valid_b_o
);

  logic       in_valid_q;
  date_t      date_a_q, date_b_q;
  logic       out_valid_q;
  order_e     order_d, order_q;
  date_info_t info_a_d, info_a_q, info_b_d, info_b_q;
  logic       out_adv, in_adv;

  // Advance each stage when it is empty or its word moves on
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  // Hold the accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      date_a_q <= '{year: year_a_i, month: month_a_i, day: day_a_i,
                    hour: hour_a_i, minute: minute_a_i, second: second_a_i};
      date_b_q <= '{year: year_b_i, month: month_b_i, day: day_b_i,
                    hour: hour_b_i, minute: minute_b_i, second: second_b_i};
    end
  end

  // Evaluate both dates and order them
  always_comb begin
    info_a_d = date_eval(date_a_q);
    info_b_d = date_eval(date_b_q);
    priority if (date_a_q.year != date_b_q.year) begin
      order_d = (date_a_q.year < date_b_q.year) ? ORD_EARLIER : ORD_LATER;
    end else if (info_a_d.doy != info_b_d.doy) begin
      order_d = (info_a_d.doy < info_b_d.doy) ? ORD_EARLIER : ORD_LATER;
    end else if (info_a_d.sod != info_b_d.sod) begin
      order_d = (info_a_d.sod < info_b_d.sod) ? ORD_EARLIER : ORD_LATER;
    end else begin
      order_d = ORD_EQUAL;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      order_q  <= order_d;
      info_a_q <= info_a_d;
      info_b_q <= info_b_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign order_o           = order_q;
  assign day_of_year_a_o   = info_a_q.doy;
  assign second_of_day_a_o = info_a_q.sod;
  assign valid_a_o         = info_a_q.ok;
  assign day_of_year_b_o   = info_b_q.doy;
  assign second_of_day_b_o = info_b_q.sod;
  assign valid_b_o         = info_b_q.ok;

endmodule
